### hdl/frt_pkg.sv
// Shared constants, codes and types of the three-port frame router.
// Used by frt_framer and three_port_frame_router; depends on nothing.
package frt_pkg;

    // Frame and port sizes
    localparam int MAX_PAYLOAD = 16;
    localparam int NPORTS      = 3;
    localparam int PORT_W      = 2;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int POS_W       = $clog2(MAX_PAYLOAD + 5);
    localparam int PHASE_W     = 3;

    // Port codes
    localparam logic [PORT_W-1:0] PORT_MASTER = 2'd0;
    localparam logic [PORT_W-1:0] PORT_SLAVE1 = 2'd1;
    localparam logic [PORT_W-1:0] PORT_SLAVE2 = 2'd2;
    localparam logic [PORT_W-1:0] PORT_NONE   = 2'd3;

    // Frame bytes
    localparam logic [BYTE_W-1:0] HDR_A   = 8'h45;
    localparam logic [BYTE_W-1:0] HDR_B   = 8'h43;
    localparam logic [BYTE_W-1:0] SEL_ONE = 8'h01;
    localparam logic [BYTE_W-1:0] SEL_TWO = 8'h02;

    // Parser phases
    localparam logic [PHASE_W-1:0] PH_HUNT = 3'd0;
    localparam logic [PHASE_W-1:0] PH_H1   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_H2   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEN  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA = 3'd4;

    // Positions within an outgoing frame
    localparam logic [POS_W-1:0] POS_TAG  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HDR1 = POS_W'(1);
    localparam logic [POS_W-1:0] POS_HDR2 = POS_W'(2);
    localparam logic [POS_W-1:0] POS_HDR3 = POS_W'(3);
    localparam logic [POS_W-1:0] POS_LEN  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_DATA = POS_W'(5);

    // Per-port parser entry
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [LEN_W-1:0]   len;
        logic [LEN_W-1:0]   count;
    } t_parse;

    // Payload store write request
    typedef struct packed {
        logic              en;
        logic [PORT_W-1:0] port;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
    } t_pay_wr;

    // Frame send request
    typedef struct packed {
        logic              start;
        logic [PORT_W-1:0] port;
        logic [PORT_W-1:0] dest;
        logic              tag_en;
        logic [LEN_W-1:0]  len;
    } t_emit_req;

endpackage

### hdl/frt_framer.sv
// Payload store and outgoing frame sequencer of the three-port frame router.
// Depends on frt_pkg.
module frt_framer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  frt_pkg::t_pay_wr             i_wr,
    input  frt_pkg::t_emit_req           i_req,
    output logic                         o_busy,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output logic [frt_pkg::BYTE_W-1:0]   o_tdata,   // tx_byte
    output logic [frt_pkg::PORT_W-1:0]   o_tuser,   // dest_port
    output logic                         o_tlast    // frame_end
);
    import frt_pkg::*;

    logic [BYTE_W-1:0] pay_mem [NPORTS][MAX_PAYLOAD];

    logic              r_busy;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [LEN_W-1:0]  r_len;
    logic [PORT_W-1:0] r_dest;
    logic [PORT_W-1:0] r_port;
    logic [BYTE_W-1:0] r_rdata;
    logic              r_ovalid;
    logic [BYTE_W-1:0] r_odata;
    logic [PORT_W-1:0] r_odest;
    logic              r_olast;

    logic              load;
    logic              last;
    logic [BYTE_W-1:0] cur_byte;
    logic [POS_W-1:0]  rd_off;
    logic [PORT_W-1:0] rd_port;

    // Move one byte into the output register when it is free or being taken
    assign load = r_busy && (!r_ovalid || i_tready);
    assign last = (r_pos == POS_LEN + POS_W'(r_len));

    // Next position; the payload read is addressed with it, so the read data matches the registered position
    always_comb begin
        if (i_req.start) begin
            n_pos = i_req.tag_en ? POS_TAG : POS_HDR1;
        end else if (load) begin
            n_pos = r_pos + POS_W'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    assign rd_off  = n_pos - POS_DATA;
    assign rd_port = i_req.start ? i_req.port : r_port;

    // Payload store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            pay_mem[i_wr.port][i_wr.idx] <= i_wr.data;
        end
        r_rdata <= pay_mem[rd_port][rd_off[IDX_W-1:0]];
    end

    // Select the byte for the current position
    always_comb begin
        case (r_pos)
            POS_TAG:  cur_byte = BYTE_W'(r_port);
            POS_HDR1: cur_byte = HDR_A;
            POS_HDR2: cur_byte = HDR_B;
            POS_HDR3: cur_byte = HDR_A;
            POS_LEN:  cur_byte = BYTE_W'(r_len);
            default:  cur_byte = r_rdata;
        endcase
    end

    // Hold the frame description and advance the position
    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        if (i_req.start) begin
            r_len  <= i_req.len;
            r_dest <= i_req.dest;
            r_port <= i_req.port;
        end
    end

    // Sequencer and output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (load && last) begin
                r_busy <= 1'b0;
            end
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_odata <= cur_byte;
            r_odest <= r_dest;
            r_olast <= last;
        end
    end

    assign o_busy   = r_busy;
    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tuser  = r_odest;
    assign o_tlast  = r_olast;

endmodule

### hdl/three_port_frame_router.sv
// Top level of the three-port frame router: per-port parser state memory and control.
// Depends on frt_pkg and frt_framer.
//
// Routes framed bytes between a master port and two slave ports. Each received
// byte arrives with its port number in s_axis_tuser. A kept input byte is
// handled in steps: a read of the port's parser entry from the state memory,
// then an update that writes it back. A byte that completes a frame then starts
// the frame readout from the payload store at one byte per cycle unless
// m_axis_tready holds it off: 4 header bytes, the payload (up to 16 bytes)
// and, for slave frames in tagged mode, a leading tag byte; input is held off
// until the last byte of the frame has entered the output register.
// Bytes on port 3, and slave bytes before the master has sent 0x45, are
// accepted and dropped without the update step.
module three_port_frame_router (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [frt_pkg::BYTE_W-1:0]   s_axis_tdata,   // rx_byte
    input  logic [frt_pkg::PORT_W-1:0]   s_axis_tuser,   // source_port
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [frt_pkg::BYTE_W-1:0]   m_axis_tdata,   // tx_byte
    output logic [frt_pkg::PORT_W-1:0]   m_axis_tuser,   // dest_port
    output logic                         m_axis_tlast    // frame_end
);
    import frt_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_PROC = 1'b1;

    t_parse            st_mem [NPORTS];
    t_parse            r_st_rdata;
    logic [NPORTS-1:0] r_st_valid;

    logic              r_state;
    logic [PORT_W-1:0] r_port;
    logic [BYTE_W-1:0] r_byte;
    logic              r_armed;
    logic              r_tagged;
    logic [PORT_W-1:0] r_sel;

    logic              n_armed;
    logic              n_tagged;
    logic [PORT_W-1:0] n_sel;
    logic              accept;
    logic              keep;
    logic              framer_busy;
    t_parse            cur;
    t_parse            nxt;
    t_pay_wr           pay_wr;
    t_emit_req         req;
    logic [LEN_W-1:0]  cnt_inc;
    logic              complete;

    assign s_axis_tready = (r_state == ST_IDLE) && !framer_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign keep = (s_axis_tuser != PORT_NONE) && (s_axis_tuser == PORT_MASTER || r_armed);

    // State memory: read at the input port every cycle, write back in the update cycle
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PROC) begin
            st_mem[r_port] <= nxt;
        end
        r_st_rdata <= st_mem[s_axis_tuser];
    end

    // Latch the request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_port <= s_axis_tuser;
            r_byte <= s_axis_tdata;
        end
    end

    // Entries never written read as hunting with zero counts
    assign cur     = r_st_valid[r_port] ? r_st_rdata : '0;
    assign cnt_inc = cur.count + LEN_W'(1);

    // Parser update for one byte
    always_comb begin
        nxt      = cur;
        n_armed  = r_armed;
        n_tagged = r_tagged;
        n_sel    = r_sel;
        complete = 1'b0;
        pay_wr   = '0;
        req      = '0;
        case (cur.phase)
            PH_H1: begin
                nxt.phase = (r_byte == HDR_B) ? PH_H2 : PH_HUNT;
            end
            PH_H2: begin
                nxt.phase = (r_byte == HDR_A) ? PH_LEN : PH_HUNT;
            end
            PH_LEN: begin
                if (r_byte > BYTE_W'(MAX_PAYLOAD)) begin
                    nxt.phase = PH_HUNT;
                end else begin
                    nxt.len   = r_byte[LEN_W-1:0];
                    nxt.count = '0;
                    nxt.phase = PH_DATA;
                    complete  = (r_byte == '0);
                end
            end
            PH_DATA: begin
                pay_wr.en   = 1'b1;
                pay_wr.port = r_port;
                pay_wr.idx  = cur.count[IDX_W-1:0];
                pay_wr.data = r_byte;
                nxt.count   = cnt_inc;
                complete    = (cnt_inc >= cur.len);
            end
            default: begin
                nxt.phase = PH_HUNT;
                if (r_byte == HDR_A) begin
                    nxt.phase = PH_H1;
                    if (r_port == PORT_MASTER) begin
                        n_armed = 1'b1;
                    end
                end else if (r_port == PORT_MASTER &&
                             (r_byte == SEL_ONE || r_byte == SEL_TWO)) begin
                    n_sel    = r_byte[PORT_W-1:0];
                    n_tagged = 1'b1;
                end
            end
        endcase

        // Finish the frame and hand it to the framer
        if (complete) begin
            nxt.phase  = PH_HUNT;
            nxt.count  = '0;
            req.start  = (r_state == ST_PROC);
            req.port   = r_port;
            req.len    = nxt.len;
            if (r_port == PORT_MASTER) begin
                req.dest   = (r_sel == PORT_SLAVE2) ? PORT_SLAVE2 : PORT_SLAVE1;
                req.tag_en = 1'b0;
                n_sel      = PORT_MASTER;
            end else begin
                req.dest   = PORT_MASTER;
                req.tag_en = r_tagged;
            end
        end

        // Only the update cycle acts
        if (r_state != ST_PROC) begin
            pay_wr.en = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_st_valid <= '0;
            r_armed    <= 1'b0;
            r_tagged   <= 1'b0;
            r_sel      <= PORT_MASTER;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept && keep) begin
                        r_state <= ST_PROC;
                    end
                end
                ST_PROC: begin
                    r_state            <= ST_IDLE;
                    r_st_valid[r_port] <= 1'b1;
                    r_armed            <= n_armed;
                    r_tagged           <= n_tagged;
                    r_sel              <= n_sel;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    frt_framer u_framer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (pay_wr),
        .i_req    (req),
        .o_busy   (framer_busy),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule
